@@ rtl/progress_bar_overlay_shader_defines.svh @@
// Assertion macros used by the checker file of the progress bar overlay.
`ifndef PROGRESS_BAR_OVERLAY_SHADER_DEFINES_SVH
`define PROGRESS_BAR_OVERLAY_SHADER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pbos_pkg.sv @@
package pbos_pkg;

    localparam int COORD_W   = 12;
    localparam int PERCENT_W = 7;
    localparam int GREY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 12;
    localparam int STEP_W    = 5;
    localparam int PROD_W    = COORD_W + PERCENT_W;
    localparam int FILL_W    = 20;
    localparam int POS_W     = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS_PERCENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_VALID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_BOTTOM    = 3'd4;

    localparam logic [COORD_W-1:0]   RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [COORD_W-1:0]   RST_SCREEN_HEIGHT = 12'd480;

    localparam logic [COORD_W-1:0]   ANCHOR_GAP     = 12'd28;
    localparam logic [COORD_W-1:0]   SIDE_MARGIN    = 12'd40;
    localparam logic [PERCENT_W-1:0] PERCENT_MAX    = 7'd100;
    localparam logic [COORD_W-1:0]   HL_MIN_LEN     = 12'd4;
    localparam logic [COORD_W-1:0]   HL_INSET       = 12'd2;
    localparam logic [POS_W-1:0]     HL_ROW         = 14'd2;
    localparam int                   GRADE_STEPS    = 28;
    localparam logic [GREY_W-1:0]    BASE_EMPTY     = 8'd34;
    localparam logic [GREY_W-1:0]    BASE_FULL      = 8'd214;
    localparam logic [GREY_W-1:0]    HIGHLIGHT_GREY = 8'd95;
    localparam logic [GREY_W-1:0]    GREY_MAX       = 8'd241;

    typedef struct packed {
        logic [COORD_W-1:0]   len;
        logic [COORD_W-2:0]   x0;
        logic [COORD_W:0]     y0;
        logic [PROD_W-1:0]    prod;
        logic signed [POS_W-1:0] right_start;
        logic [COORD_W-1:0]   hl_end;
    } t_geom;

endpackage

@@ rtl/pbos_pixel_if.sv @@
interface pbos_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [pbos_pkg::COORD_W-1:0]   pixel_x;
    logic [pbos_pkg::COORD_W-1:0]   pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/pbos_shade_if.sv @@
interface pbos_shade_if;
    logic                           valid;
    logic                           ready;
    logic                           covered;
    logic [pbos_pkg::GREY_W-1:0]    grey_level;

    modport source (output valid, output covered, output grey_level, input ready);
    modport sink (input valid, input covered, input grey_level, output ready);
endinterface

@@ rtl/progress_bar_overlay_shader.sv @@
// Progress bar overlay shader. Each pixel word (pixel_x, pixel_y) on i_pixel yields one shade
// word (covered, grey_level) on o_shade, in order. The block takes one word per clock cycle
// while the output is not stalled; a word passes an input register and then a result register,
// and the output register lets a new word in while a finished one waits. Bar geometry is
// recomputed from the configuration registers into a register every cycle, so configuration
// must be written while the block is idle and one spare cycle must pass before the next pixel
// word is sent.
module progress_bar_overlay_shader #(
    parameter int BAR_LENGTH    = 630,
    parameter int BAR_THICKNESS = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pbos_pixel_if.sink                         i_pixel,
    pbos_shade_if.source                       o_shade,
    input  logic                               i_cfg_we,
    input  logic [pbos_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pbos_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int Rad          = BAR_THICKNESS / 2;
    localparam int RadW         = $clog2(Rad + 1);
    localparam int SqW          = 2 * RadW + 1;
    localparam int RowW         = $clog2(BAR_THICKNESS);
    localparam int StepTabN     = 2 ** RowW;
    localparam int CW           = pbos_pkg::COORD_W;
    localparam int PW           = pbos_pkg::POS_W;
    localparam logic [CW-1:0]   BarLen   = CW'(BAR_LENGTH);
    localparam logic [CW-1:0]   Thick    = CW'(BAR_THICKNESS);
    localparam logic [PW-1:0]   RadPos   = PW'(Rad);
    localparam logic [PW-1:0]   ThickPos = PW'(BAR_THICKNESS);
    localparam logic [PW-1:0]   BotStart = PW'(BAR_THICKNESS - Rad);
    localparam logic [PW-1:0]   BotBase  = PW'(BAR_THICKNESS - Rad - 1);
    localparam logic [SqW-1:0]  RadSq    = SqW'(Rad * Rad);

    // Configuration registers
    logic [CW-1:0]                      r_screen_width;
    logic [CW-1:0]                      r_screen_height;
    logic [pbos_pkg::PERCENT_W-1:0]     r_percent;
    logic                               r_anchor_valid;
    logic [CW-1:0]                      r_anchor_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= pbos_pkg::RST_SCREEN_WIDTH;
            r_screen_height <= pbos_pkg::RST_SCREEN_HEIGHT;
            r_percent       <= '0;
            r_anchor_valid  <= 1'b0;
            r_anchor_bottom <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbos_pkg::CFG_SCREEN_WIDTH: begin
                    r_screen_width <= i_cfg_data[CW-1:0];
                end
                pbos_pkg::CFG_SCREEN_HEIGHT: begin
                    r_screen_height <= i_cfg_data[CW-1:0];
                end
                pbos_pkg::CFG_PROGRESS_PERCENT: begin
                    r_percent <= i_cfg_data[pbos_pkg::PERCENT_W-1:0];
                end
                pbos_pkg::CFG_ANCHOR_VALID: begin
                    r_anchor_valid <= i_cfg_data[0];
                end
                pbos_pkg::CFG_ANCHOR_BOTTOM: begin
                    r_anchor_bottom <= i_cfg_data[CW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Bar geometry, derived from the configuration
    pbos_pkg::t_geom                n_geom;
    pbos_pkg::t_geom                r_geom;
    logic [CW-1:0]                  w_max_len;
    logic [CW-1:0]                  w_len;
    logic [pbos_pkg::PERCENT_W-1:0] w_pct_sat;

    always_comb begin
        w_max_len = (r_screen_width > pbos_pkg::SIDE_MARGIN) ?
                    r_screen_width - pbos_pkg::SIDE_MARGIN : r_screen_width;
        w_len     = (BarLen > w_max_len) ? w_max_len : BarLen;
        w_pct_sat = (r_percent > pbos_pkg::PERCENT_MAX) ? pbos_pkg::PERCENT_MAX : r_percent;

        n_geom.len  = w_len;
        n_geom.x0   = (CW-1)'((r_screen_width - w_len) >> 1);
        if (r_anchor_valid) begin
            n_geom.y0 = {1'b0, r_anchor_bottom} + {1'b0, pbos_pkg::ANCHOR_GAP};
        end else if (r_screen_height > Thick) begin
            n_geom.y0 = {1'b0, (r_screen_height - Thick) >> 1};
        end else begin
            n_geom.y0 = '0;
        end
        n_geom.prod        = pbos_pkg::PROD_W'(w_len) * pbos_pkg::PROD_W'(w_pct_sat);
        n_geom.right_start = $signed(PW'(w_len)) - $signed(RadPos);
        n_geom.hl_end      = (w_len > pbos_pkg::HL_MIN_LEN) ?
                             w_len - pbos_pkg::HL_INSET : pbos_pkg::HL_INSET;
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    // Shade step for each bar row
    logic [pbos_pkg::STEP_W-1:0] w_step_tab [StepTabN];

    for (genvar g = 0; g < StepTabN; g++) begin : g_step
        localparam int StepVal =
            (g < BAR_THICKNESS) ? (g * pbos_pkg::GRADE_STEPS) / BAR_THICKNESS : 0;
        assign w_step_tab[g] = pbos_pkg::STEP_W'(StepVal);
    end

    // Handshake and pipeline control
    logic r_v1;
    logic r_v2;
    logic w_adv1;
    logic w_adv2;

    assign w_adv2        = !r_v2 || o_shade.ready;
    assign w_adv1        = !r_v1 || w_adv2;
    assign i_pixel.ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_pixel.valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Input register
    logic [CW-1:0] r_px;
    logic [CW-1:0] r_py;

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_pixel.valid) begin
            r_px <= i_pixel.pixel_x;
            r_py <= i_pixel.pixel_y;
        end
    end

    // Per-pixel coverage and shade
    logic signed [PW-1:0]       w_col;
    logic signed [PW-1:0]       w_row;
    logic                       w_on_screen;
    logic                       w_in_bar;
    logic [RadW-1:0]            w_dx;
    logic [RadW-1:0]            w_dy;
    logic [SqW-1:0]             w_dist;
    logic                       w_corner_ok;
    logic [pbos_pkg::FILL_W-1:0] w_fill_lhs;
    logic                       w_filled;
    logic                       w_highlight;
    logic                       n_cov;
    logic [pbos_pkg::GREY_W-1:0] n_grey;

    always_comb begin
        w_col = $signed({2'b00, r_px}) - $signed({3'b000, r_geom.x0});
        w_row = $signed({2'b00, r_py}) - $signed({1'b0, r_geom.y0});

        w_on_screen = (r_px < r_screen_width) && (r_py < r_screen_height);
        w_in_bar    = !w_row[PW-1] && (w_row < $signed(ThickPos)) &&
                      !w_col[PW-1] && (w_col < $signed({2'b00, r_geom.len}));

        if (w_col < $signed(RadPos)) begin
            w_dx = RadW'($signed(RadPos) - w_col);
        end else if (w_col >= r_geom.right_start) begin
            w_dx = RadW'(w_col - r_geom.right_start + 14'sd1);
        end else begin
            w_dx = '0;
        end

        if (w_row < $signed(RadPos)) begin
            w_dy = RadW'($signed(RadPos) - w_row);
        end else if (w_row >= $signed(BotStart)) begin
            w_dy = RadW'(w_row - $signed(BotBase));
        end else begin
            w_dy = '0;
        end

        w_dist      = SqW'(SqW'(w_dx) * SqW'(w_dx)) + SqW'(SqW'(w_dy) * SqW'(w_dy));
        w_corner_ok = (w_dist <= RadSq);

        // The filled part ends at len*percent/100: compare without dividing.
        w_fill_lhs = pbos_pkg::FILL_W'(w_col[CW-1:0]) + pbos_pkg::FILL_W'(1);
        w_filled   = pbos_pkg::FILL_W'(w_fill_lhs * pbos_pkg::FILL_W'(pbos_pkg::PERCENT_MAX))
                     <= pbos_pkg::FILL_W'(r_geom.prod);

        w_highlight = (w_row == $signed(pbos_pkg::HL_ROW)) &&
                      (w_col >= $signed(PW'(pbos_pkg::HL_INSET))) &&
                      (w_col < $signed({2'b00, r_geom.hl_end}));

        n_cov  = 1'b0;
        n_grey = '0;
        if (w_on_screen) begin
            if (w_in_bar && w_corner_ok) begin
                n_cov  = 1'b1;
                n_grey = (w_filled ? pbos_pkg::BASE_FULL : pbos_pkg::BASE_EMPTY) +
                         pbos_pkg::GREY_W'(w_step_tab[w_row[RowW-1:0]]);
            end
            if (w_highlight) begin
                n_cov  = 1'b1;
                n_grey = pbos_pkg::HIGHLIGHT_GREY;
            end
        end
    end

    // Result register
    logic                        r_cov;
    logic [pbos_pkg::GREY_W-1:0] r_grey;

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            r_cov  <= n_cov;
            r_grey <= n_grey;
        end
    end

    assign o_shade.valid      = r_v2;
    assign o_shade.covered    = r_cov;
    assign o_shade.grey_level = r_grey;

endmodule

@@ rtl/pbos_checker.sv @@
`include "progress_bar_overlay_shader_defines.svh"

module pbos_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_covered,
    input logic [pbos_pkg::GREY_W-1:0]    i_grey_level
);

    // An uncovered pixel always carries a zero grey level.
    `PBOS_ASSERT_NOW(a_uncovered_black, i_out_valid && !i_covered, i_grey_level == '0,
        "uncovered word has nonzero grey")

    // A covered pixel is either the highlight or a graded bar shade.
    `PBOS_ASSERT_NOW(a_covered_range, i_out_valid && i_covered,
        (i_grey_level == pbos_pkg::HIGHLIGHT_GREY) ||
        ((i_grey_level >= pbos_pkg::BASE_EMPTY) && (i_grey_level <= pbos_pkg::GREY_MAX)),
        "covered word has an impossible grey")

    // With the output register empty the block must take a new word.
    `PBOS_ASSERT_NOW(a_ready_when_empty, !i_out_valid, i_in_ready,
        "input stalled with empty output")

    // A stalled result word holds.
    `PBOS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_covered) && $stable(i_grey_level),
        "stalled result word changed")

endmodule

bind progress_bar_overlay_shader pbos_checker u_pbos_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pixel.ready),
    .i_out_valid  (o_shade.valid),
    .i_out_ready  (o_shade.ready),
    .i_covered    (o_shade.covered),
    .i_grey_level (o_shade.grey_level)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import pbos_pkg::*;

    localparam int BAR_LEN         = 630;
    localparam int BAR_ROWS        = 18;
    localparam int CORNER_R        = BAR_ROWS / 2;
    localparam int ANCHOR_DROP     = 28;
    localparam int GRADE_SPAN      = 28;
    localparam int GREY_EMPTY      = 34;
    localparam int GREY_FULL       = 214;
    localparam int GREY_HIGHLIGHT  = 95;
    localparam int WIDTH_MARGIN    = 40;
    localparam int FULL_PERCENT    = 100;
    localparam int HIGHLIGHT_ROW   = 2;
    localparam int HIGHLIGHT_INSET = 2;
    localparam int HIGHLIGHT_MIN   = 4;
    localparam int COORD_MAX       = 4095;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 40;
    localparam int DIRECTED_ROWS   = 36;

    typedef struct packed {
        logic              covered;
        logic [GREY_W-1:0] grey;
    } shade_t;

    typedef struct packed {
        logic   fixed;
        shade_t shade;
    } shade_note_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   a;
        int                   b;
        bit                   fixed;
        bit                   cov;
        int                   grey;
    } dir_row_t;

    // A pixel row carries (x, y); a write row carries (value, unused).
    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_PIXEL, '0, 0, 0, 1'b1, 1'b0, 0},
        '{ROW_PIXEL, '0, 4095, 4095, 1'b1, 1'b0, 0},
        '{ROW_PIXEL, '0, 640, 240, 1'b1, 1'b0, 0},
        '{ROW_PIXEL, '0, 320, 480, 1'b1, 1'b0, 0},
        '{ROW_PIXEL, '0, 22, 233, 1'b1, 1'b1, 95},
        '{ROW_PIXEL, '0, 617, 233, 1'b1, 1'b1, 95},
        '{ROW_PIXEL, '0, 320, 240, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 20, 231, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 19, 240, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 618, 233, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_PROGRESS_PERCENT, 100, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 300, 240, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 619, 248, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_PROGRESS_PERCENT, 127, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 618, 240, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_ANCHOR_VALID, 1, 0, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_SCREEN_HEIGHT, 4095, 0, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_ANCHOR_BOTTOM, 4095, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 320, 4095, 1'b1, 1'b0, 0},
        '{ROW_WRITE, CFG_ANCHOR_BOTTOM, 100, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 22, 130, 1'b1, 1'b1, 95},
        '{ROW_WRITE, CFG_ANCHOR_VALID, 0, 0, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_SCREEN_HEIGHT, 10, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 22, 2, 1'b1, 1'b1, 95},
        '{ROW_PIXEL, '0, 320, 9, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_SCREEN_WIDTH, 30, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 15, 5, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 29, 2, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_SCREEN_WIDTH, 4, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 2, 2, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 1, 5, 1'b0, 1'b0, 0},
        '{ROW_WRITE, CFG_SCREEN_WIDTH, 0, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 0, 2, 1'b1, 1'b0, 0},
        '{ROW_WRITE, CFG_SCREEN_WIDTH, 4095, 0, 1'b0, 1'b0, 0},
        '{ROW_PIXEL, '0, 1734, 2, 1'b1, 1'b1, 95},
        '{ROW_PIXEL, '0, 4095, 5, 1'b0, 1'b0, 0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pbos_pixel_if pixel_ch ();
    pbos_shade_if shade_ch ();

    progress_bar_overlay_shader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pixel    (pixel_ch),
        .o_shade    (shade_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [COORD_W-1:0]   cfg_width;
    logic [COORD_W-1:0]   cfg_height;
    logic [PERCENT_W-1:0] cfg_percent;
    logic                 cfg_anchor_valid;
    logic [COORD_W-1:0]   cfg_anchor_bottom;

    shade_note_t typed_shades [$];
    shade_t      expected_shades [$];
    int          mismatches;
    int          words_seen;
    bit          steady;

    function automatic longint bar_len();
        longint sw;
        longint lim;
        sw  = cfg_width;
        lim = (sw > WIDTH_MARGIN) ? sw - WIDTH_MARGIN : sw;
        return (BAR_LEN > lim) ? lim : BAR_LEN;
    endfunction

    function automatic longint bar_left();
        longint sw;
        longint len;
        sw  = cfg_width;
        len = bar_len();
        return (sw > len) ? (sw - len) / 2 : 0;
    endfunction

    function automatic longint bar_top();
        longint sh;
        longint ab;
        sh = cfg_height;
        ab = cfg_anchor_bottom;
        if (cfg_anchor_valid) begin
            return ab + ANCHOR_DROP;
        end
        return (sh > BAR_ROWS) ? (sh - BAR_ROWS) / 2 : 0;
    endfunction

    function automatic shade_t shade_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        longint px, py, sw, sh, pct, len, fill, col, row, hl, dx, dy, g;
        shade_t s;
        px  = x;
        py  = y;
        sw  = cfg_width;
        sh  = cfg_height;
        pct = (cfg_percent > FULL_PERCENT) ? FULL_PERCENT : cfg_percent;
        len = bar_len();
        fill = (len * pct) / FULL_PERCENT;
        col = px - bar_left();
        row = py - bar_top();
        s   = '0;
        if (px < sw && py < sh) begin
            if (row >= 0 && row < BAR_ROWS && col >= 0 && col < len) begin
                dx = 0;
                dy = 0;
                if (col < CORNER_R) begin
                    dx = CORNER_R - col;
                end else if (col >= len - CORNER_R) begin
                    dx = col - (len - CORNER_R - 1);
                end
                if (row < CORNER_R) begin
                    dy = CORNER_R - row;
                end else if (row >= BAR_ROWS - CORNER_R) begin
                    dy = row - (BAR_ROWS - CORNER_R - 1);
                end
                if (dx * dx + dy * dy <= CORNER_R * CORNER_R) begin
                    g = ((col < fill) ? GREY_FULL : GREY_EMPTY) + (row * GRADE_SPAN) / BAR_ROWS;
                    s.covered = 1'b1;
                    s.grey    = g[GREY_W-1:0];
                end
            end
            hl = (len > HIGHLIGHT_MIN) ? len - 2 * HIGHLIGHT_INSET : 0;
            if (row == HIGHLIGHT_ROW && col >= HIGHLIGHT_INSET && col < HIGHLIGHT_INSET + hl) begin
                s.covered = 1'b1;
                s.grey    = GREY_HIGHLIGHT;
            end
        end
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic fixed,
                              shade_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.pixel_x <= x;
        pixel_ch.pixel_y <= y;
        typed_shades.push_back('{fixed, want});
        @(posedge i_clk);
        while (!pixel_ch.ready) @(posedge i_clk);
    endtask

    task automatic settle();
        pixel_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_shades.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:     cfg_width         = value[COORD_W-1:0];
            CFG_SCREEN_HEIGHT:    cfg_height        = value[COORD_W-1:0];
            CFG_PROGRESS_PERCENT: cfg_percent       = value[PERCENT_W-1:0];
            CFG_ANCHOR_VALID:     cfg_anchor_valid  = value[0];
            CFG_ANCHOR_BOTTOM:    cfg_anchor_bottom = value[COORD_W-1:0];
            default: ;
        endcase
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        return v[COORD_W-1:0];
    endfunction

    task automatic pick_pixel(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        int     mode;
        longint xx;
        longint yy;
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            yy = bar_top() - 3 + $urandom_range(0, BAR_ROWS + 5);
            case ($urandom_range(0, 3))
                0:       xx = bar_left() - 3 + $urandom_range(0, 14);
                1:       xx = bar_left() + bar_len() - 11 + $urandom_range(0, 14);
                default: xx = $urandom_range(0, cfg_width);
            endcase
        end else if (mode <= 7) begin
            xx = $urandom_range(0, cfg_width);
            yy = $urandom_range(0, cfg_height);
        end else begin
            xx = $urandom_range(0, COORD_MAX);
            yy = $urandom_range(0, COORD_MAX);
        end
        x = clamp_coord(xx);
        y = clamp_coord(yy);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        shade_note_t note;
        shade_t      want;
        shade_t      got;
        int          spell_left;
        int          stall;
        shade_ch.ready = 1'b0;
        spell_left     = 0;
        forever begin
            @(posedge i_clk);
            if (pixel_ch.valid && pixel_ch.ready) begin
                note = typed_shades.pop_front();
                expected_shades.push_back(note.fixed ? note.shade
                                          : shade_pixel(pixel_ch.pixel_x, pixel_ch.pixel_y));
            end
            if (shade_ch.valid && shade_ch.ready) begin
                got.covered = shade_ch.covered;
                got.grey    = shade_ch.grey_level;
                if (expected_shades.size() == 0) begin
                    report_mismatch($sformatf("shade word %0d arrived with none expected",
                                              words_seen));
                end else begin
                    want = expected_shades.pop_front();
                    if (got.covered !== want.covered) begin
                        report_mismatch($sformatf("word %0d covered: got %0b, expected %0b",
                                                  words_seen, got.covered, want.covered));
                    end
                    if (got.grey !== want.grey) begin
                        report_mismatch($sformatf("word %0d grey_level: got %0d, expected %0d",
                                                  words_seen, got.grey, want.grey));
                    end
                end
                words_seen++;
            end
            if (spell_left > 0) begin
                spell_left--;
            end else if (shade_ch.ready) begin
                stall = pick_gap();
                if (stall > 0) begin
                    shade_ch.ready <= 1'b0;
                    spell_left = stall - 1;
                end else begin
                    spell_left = $urandom_range(1, 16);
                end
            end else begin
                shade_ch.ready <= 1'b1;
                spell_left = $urandom_range(1, 24);
            end
        end
    end

    initial begin
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        int w, h, pct, av, ab;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        pixel_ch.valid    = 1'b0;
        pixel_ch.pixel_x  = '0;
        pixel_ch.pixel_y  = '0;
        cfg_width         = 12'd640;
        cfg_height        = 12'd480;
        cfg_percent       = '0;
        cfg_anchor_valid  = 1'b0;
        cfg_anchor_bottom = '0;
        mismatches        = 0;
        words_seen        = 0;
        steady            = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                settle();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].a);
            end else begin
                send_pixel(DIRECTED[i].a[COORD_W-1:0], DIRECTED[i].b[COORD_W-1:0],
                           DIRECTED[i].fixed, '{DIRECTED[i].cov, DIRECTED[i].grey[GREY_W-1:0]});
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            steady = (p % 4 == 3);
            if (p == 0) begin
                w = 64; h = 64; pct = 0; av = 0; ab = 0;
            end else if (p == 1) begin
                w = COORD_MAX; h = COORD_MAX; pct = 127; av = 1; ab = 2000;
            end else begin
                case ($urandom_range(0, 7))
                    0:       w = $urandom_range(0, 45);
                    1:       w = 64;
                    2:       w = COORD_MAX;
                    default: w = $urandom_range(64, COORD_MAX);
                endcase
                case ($urandom_range(0, 7))
                    0:       h = $urandom_range(0, 30);
                    1:       h = 64;
                    2:       h = COORD_MAX;
                    default: h = $urandom_range(64, COORD_MAX);
                endcase
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = FULL_PERCENT;
                    2:       pct = 127;
                    default: pct = $urandom_range(0, 127);
                endcase
                av = $urandom_range(0, 1);
                ab = ($urandom_range(0, 3) == 0) ? $urandom_range(0, COORD_MAX)
                                                 : $urandom_range(0, h);
            end
            write_reg(CFG_SCREEN_WIDTH, w);
            write_reg(CFG_SCREEN_HEIGHT, h);
            write_reg(CFG_PROGRESS_PERCENT, pct);
            write_reg(CFG_ANCHOR_VALID, av);
            write_reg(CFG_ANCHOR_BOTTOM, ab);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                pick_pixel(x, y);
                send_pixel(x, y, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
